### sv/bgg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgg_pkg
// Shared types, widths and helpers of the bilinear gradient generator.
// ----------------------------------------------------------------------------
package bgg_pkg;

    // fixed field widths
    localparam int IMG_W        = 13;
    localparam int BORD_W       = 12;
    localparam int COLOR_W      = 32;
    localparam int DIV_W        = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_SIDE_DEF = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_TR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_BR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_C  = 3'd7;

    // image geometry as seen by the front end
    typedef struct packed {
        logic [IMG_W-1:0]  width;
        logic [IMG_W-1:0]  height;
        logic [BORD_W-1:0] border;
    } t_geom;

    // colours as seen by the back end
    typedef struct packed {
        logic [COLOR_W-1:0] tl;
        logic [COLOR_W-1:0] tr;
        logic [COLOR_W-1:0] bl;
        logic [COLOR_W-1:0] br;
        logic [COLOR_W-1:0] border;
    } t_colors;

    // one classified pixel, front to back
    typedef struct packed {
        logic             setup_edges;
        logic             setup_row;
        logic             inner;
        logic             advance;
        logic             end_of_row;
        logic             end_of_frame;
        logic             edge_nz;
        logic             row_nz;
        logic [DIV_W-1:0] edge_div;
        logic [DIV_W-1:0] row_div;
    } t_cmd;

    // divider request
    typedef struct packed {
        logic               start;
        logic [COLOR_W-1:0] dividend;
        logic [DIV_W-1:0]   divisor;
    } t_div_req;

    // one colour component as an 8.16 value with a half bit
    function automatic logic [COLOR_W-1:0] unpack_comp(input logic [COLOR_W-1:0] rgba,
                                                       input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0: c = rgba[31:24];
            2'd1: c = rgba[23:16];
            2'd2: c = rgba[15:8];
            default: c = rgba[7:0];
        endcase
        return {8'h00, c, 16'h8000};
    endfunction

endpackage
`default_nettype wire

### sv/bgg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgg_front
// Tracks the raster position and classifies each requested pixel.
// ----------------------------------------------------------------------------
module bgg_front #(
    parameter int MAX_SIDE = bgg_pkg::MAX_SIDE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bgg_pkg::t_geom i_geom,
    input  wire logic          i_valid,
    input  wire logic          i_restart,
    input  wire logic          i_full,
    output logic               o_stall,
    output logic               o_push,
    output bgg_pkg::t_cmd      o_cmd
);
    import bgg_pkg::*;

    localparam int CNT_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int CMP_W = (CNT_W + 1 > IMG_W + 1) ? CNT_W + 1 : IMG_W + 1;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SIDE);

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CMP_W-1:0] ext_w, ext_h, w, h, bsz, b2, iw, ih;
    logic [CMP_W-1:0] x0, y0, x1, y1, x, y;
    logic             all_b, inner;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // position and classification
    always_comb begin
        ext_w = CMP_W'(i_geom.width);
        ext_h = CMP_W'(i_geom.height);
        w     = (ext_w == '0) ? CMP_W'(1) : ((ext_w > MAX_C) ? MAX_C : ext_w);
        h     = (ext_h == '0) ? CMP_W'(1) : ((ext_h > MAX_C) ? MAX_C : ext_h);
        bsz   = CMP_W'(i_geom.border);
        b2    = bsz << 1;
        all_b = (b2 >= w) || (b2 >= h);
        iw    = w - b2;
        ih    = h - b2;

        x0 = i_restart ? '0 : CMP_W'(r_col);
        y0 = i_restart ? '0 : CMP_W'(r_row);
        if (x0 >= w) begin
            x1 = '0;
            y1 = y0 + CMP_W'(1);
        end else begin
            x1 = x0;
            y1 = y0;
        end
        if (y1 >= h) begin
            x = '0;
            y = '0;
        end else begin
            x = x1;
            y = y1;
        end

        inner = !all_b && (x >= bsz) && (y >= bsz) && (x < w - bsz) && (y < h - bsz);

        o_cmd.setup_edges  = (x == '0) && (y == '0);
        o_cmd.setup_row    = inner && (x == bsz);
        o_cmd.inner        = inner;
        o_cmd.advance      = inner && (x == w - bsz - CMP_W'(1));
        o_cmd.end_of_row   = (x == w - CMP_W'(1));
        o_cmd.end_of_frame = (x == w - CMP_W'(1)) && (y == h - CMP_W'(1));
        o_cmd.edge_nz      = !all_b && (ih > CMP_W'(1));
        o_cmd.row_nz       = !all_b && (iw > CMP_W'(1));
        o_cmd.edge_div     = DIV_W'(ih - CMP_W'(1));
        o_cmd.row_div      = DIV_W'(iw - CMP_W'(1));

        // next position
        if (x + CMP_W'(1) >= w) begin
            n_col = '0;
            n_row = (y + CMP_W'(1) >= h) ? '0 : CNT_W'(y + CMP_W'(1));
        end else begin
            n_col = CNT_W'(x + CMP_W'(1));
            n_row = CNT_W'(y);
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

### sv/bgg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgg_fifo
// Two-entry queue of classified pixels between front and back end.
// ----------------------------------------------------------------------------
module bgg_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bgg_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output bgg_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import bgg_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

### sv/bgg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgg_div
// Signed 32-bit by unsigned divisor, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgg_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bgg_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [31:0]            o_quot
);
    import bgg_pkg::*;

    logic [31:0]      r_q;
    logic [DIV_W-1:0] r_rem, r_div;
    logic             r_neg, r_busy, r_done;
    logic [4:0]       r_cnt;
    logic [DIV_W:0]   trial, diff;
    logic             ge;
    logic [31:0]      mag;

    // restoring step
    always_comb begin
        trial = {r_rem, r_q[31]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        mag   = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[31];
            r_cnt <= '1;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], ge};
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### sv/bgg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgg_back
// Edge and row set-up through the shared divider, pixel blend and output word.
// ----------------------------------------------------------------------------
module bgg_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bgg_pkg::t_colors i_colors,
    input  wire bgg_pkg::t_cmd   i_head,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [31:0]          o_pixel,
    output logic                 o_end_of_row,
    output logic                 o_end_of_frame
);
    import bgg_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_EDGE_ISSUE = 3'd1;
    localparam logic [2:0] S_EDGE_WAIT  = 3'd2;
    localparam logic [2:0] S_ROW_ISSUE  = 3'd3;
    localparam logic [2:0] S_ROW_WAIT   = 3'd4;
    localparam logic [2:0] S_ROW_LOAD   = 3'd5;
    localparam logic [2:0] S_EMIT       = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    t_cmd        r_cmd, e_cmd;
    logic [31:0] r_left [4];
    logic [31:0] r_right [4];
    logic [31:0] r_lstep [4];
    logic [31:0] r_rstep [4];
    logic [31:0] r_quot [4];
    logic [31:0] r_rb, r_ga, r_rb_step, r_ga_step;
    logic        r_sub_rb, r_sub_ga;
    logic        r_out_valid;
    logic [31:0] r_pixel;
    logic        r_eor, r_eof;

    logic        head_plain, out_free, emit_now;
    logic [1:0]  k;
    logic [31:0] edge_top, edge_bot, row_diff;
    logic [31:0] dr, dg, db, da;
    t_div_req    div_req;
    logic        div_done;
    logic [31:0] div_quot;

    bgg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid    = r_out_valid;
    assign o_pixel        = r_pixel;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

    // handshake and emit decision
    always_comb begin
        head_plain = !i_empty && !i_head.setup_edges && !i_head.setup_row;
        out_free   = !r_out_valid || !i_out_stall;
        emit_now   = out_free && (((r_state == S_IDLE) && head_plain) || (r_state == S_EMIT));
        o_pop      = (r_state == S_IDLE) && !i_empty && (!head_plain || out_free);
        e_cmd      = (r_state == S_EMIT) ? r_cmd : i_head;
    end

    // divider operands
    always_comb begin
        k        = r_idx[1:0];
        edge_top = unpack_comp(r_idx[2] ? i_colors.tr : i_colors.tl, k);
        edge_bot = unpack_comp(r_idx[2] ? i_colors.br : i_colors.bl, k);
        row_diff = r_right[k] - r_left[k];
        div_req.start    = (r_state == S_EDGE_ISSUE) ||
                           ((r_state == S_ROW_ISSUE) && r_cmd.row_nz);
        div_req.dividend = (r_state == S_EDGE_ISSUE) ? (edge_bot - edge_top) : row_diff;
        div_req.divisor  = (r_state == S_EDGE_ISSUE) ? r_cmd.edge_div : r_cmd.row_div;
    end

    // row steps with the sign folded out of the low member
    always_comb begin
        dr = r_quot[2][31] ? (32'd0 - r_quot[0]) : r_quot[0];
        db = r_quot[2][31] ? (32'd0 - r_quot[2]) : r_quot[2];
        dg = r_quot[3][31] ? (32'd0 - r_quot[1]) : r_quot[1];
        da = r_quot[3][31] ? (32'd0 - r_quot[3]) : r_quot[3];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = 3'd0;
                if (!i_empty && !head_plain) begin
                    if (i_head.setup_edges) begin
                        if (i_head.edge_nz) begin
                            n_state = S_EDGE_ISSUE;
                        end else begin
                            n_state = i_head.setup_row ? S_ROW_ISSUE : S_EMIT;
                        end
                    end else begin
                        n_state = S_ROW_ISSUE;
                    end
                end
            end
            S_EDGE_ISSUE: begin
                n_state = S_EDGE_WAIT;
            end
            S_EDGE_WAIT: begin
                if (div_done) begin
                    if (r_idx == 3'd7) begin
                        n_idx   = 3'd0;
                        n_state = r_cmd.setup_row ? S_ROW_ISSUE : S_EMIT;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_EDGE_ISSUE;
                    end
                end
            end
            S_ROW_ISSUE: begin
                n_state = r_cmd.row_nz ? S_ROW_WAIT : S_ROW_LOAD;
            end
            S_ROW_WAIT: begin
                if (div_done) begin
                    n_idx   = r_idx + 3'd1;
                    n_state = (k == 2'd3) ? S_ROW_LOAD : S_ROW_ISSUE;
                end
            end
            S_ROW_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
            r_sub_rb    <= 1'b0;
            r_sub_ga    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ROW_LOAD) begin
                r_sub_rb <= r_quot[2][31];
                r_sub_ga <= r_quot[3][31];
            end
        end
    end

    // accumulators, steps and output word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end

        // edge load at the top-left pixel
        if ((r_state == S_IDLE) && !i_empty && i_head.setup_edges) begin
            for (int i = 0; i < 4; i++) begin
                r_left[i]  <= unpack_comp(i_colors.tl, 2'(i));
                r_right[i] <= unpack_comp(i_colors.tr, 2'(i));
                if (!i_head.edge_nz) begin
                    r_lstep[i] <= 32'd0;
                    r_rstep[i] <= 32'd0;
                end
            end
        end

        // edge steps
        if ((r_state == S_EDGE_WAIT) && div_done) begin
            if (r_idx[2]) begin
                r_rstep[k] <= div_quot;
            end else begin
                r_lstep[k] <= div_quot;
            end
        end

        // row quotients
        if ((r_state == S_ROW_ISSUE) && !r_cmd.row_nz) begin
            for (int i = 0; i < 4; i++) begin
                r_quot[i] <= 32'd0;
            end
        end
        if ((r_state == S_ROW_WAIT) && div_done) begin
            r_quot[k] <= div_quot;
        end

        // row accumulators as packed 8.8 pairs
        if (r_state == S_ROW_LOAD) begin
            r_rb      <= {r_left[0][23:8], r_left[2][23:8]};
            r_ga      <= {r_left[1][23:8], r_left[3][23:8]};
            r_rb_step <= {dr[23:8], db[23:8]};
            r_ga_step <= {dg[23:8], da[23:8]};
        end

        // pixel out and stepping
        if (emit_now) begin
            r_eor <= e_cmd.end_of_row;
            r_eof <= e_cmd.end_of_frame;
            if (e_cmd.inner) begin
                r_pixel <= (r_rb & 32'hff00ff00) | ((r_ga & 32'hff00ff00) >> 8);
                r_rb    <= r_sub_rb ? (r_rb - r_rb_step) : (r_rb + r_rb_step);
                r_ga    <= r_sub_ga ? (r_ga - r_ga_step) : (r_ga + r_ga_step);
                if (e_cmd.advance) begin
                    for (int i = 0; i < 4; i++) begin
                        r_left[i]  <= r_left[i] + r_lstep[i];
                        r_right[i] <= r_right[i] + r_rstep[i];
                    end
                end
            end else begin
                r_pixel <= i_colors.border;
            end
        end
    end

endmodule
`default_nettype wire

### sv/bilinear_gradient_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_gradient_generator
// Raster pixel source: bilinear blend of four corners inside a solid border.
//
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_stall     i_restart
// out      out  o_out_valid / i_out_stall   o_pixel, o_end_of_row, o_end_of_frame
// cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One pixel per cycle in steady state while the output is not stalled, set by the back end's emit step.
// The top-left pixel adds up to 8 divisions and the first inner pixel of each
// inner row adds up to 4, all on the one bit-serial divider.
// A two-entry queue lets the front end keep taking words while the back end
// divides or the output is stalled. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_gradient_generator #(
    parameter int MAX_SIDE = bgg_pkg::MAX_SIDE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_restart,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [31:0]                      o_pixel,
    output logic                             o_end_of_row,
    output logic                             o_end_of_frame,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bgg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data
);
    import bgg_pkg::*;

    logic [COLOR_W-1:0] r_tl, r_tr, r_bl, r_br, r_border_c;
    logic [IMG_W-1:0]   r_width, r_height;
    logic [BORD_W-1:0]  r_border;
    t_geom              geom;
    t_colors            colors;
    t_cmd               cmd, head;
    logic               push, pop, empty, full;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl       <= '0;
            r_tr       <= '0;
            r_bl       <= '0;
            r_br       <= '0;
            r_width    <= IMG_W'(1);
            r_height   <= IMG_W'(1);
            r_border   <= '0;
            r_border_c <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CORNER_TL: r_tl       <= i_cfg_data;
                REG_CORNER_TR: r_tr       <= i_cfg_data;
                REG_CORNER_BL: r_bl       <= i_cfg_data;
                REG_CORNER_BR: r_br       <= i_cfg_data;
                REG_WIDTH:     r_width    <= i_cfg_data[IMG_W-1:0];
                REG_HEIGHT:    r_height   <= i_cfg_data[IMG_W-1:0];
                REG_BORDER:    r_border   <= i_cfg_data[BORD_W-1:0];
                REG_BORDER_C:  r_border_c <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom.width    = r_width;
        geom.height   = r_height;
        geom.border   = r_border;
        colors.tl     = r_tl;
        colors.tr     = r_tr;
        colors.bl     = r_bl;
        colors.br     = r_br;
        colors.border = r_border_c;
    end

    // position tracking and classification
    bgg_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_valid   (i_in_valid),
        .i_restart (i_restart),
        .i_full    (full),
        .o_stall   (o_in_stall),
        .o_push    (push),
        .o_cmd     (cmd)
    );

    // decoupling queue
    bgg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // colour set-up and pixel output
    bgg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_colors       (colors),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel        (o_pixel),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
`default_nettype wire

### tb/sv/tb_bilinear_gradient_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_gradient_generator
// Self-checking bench for the bilinear gradient pixel source. A local model of
// the edge and row accumulators predicts every pixel word. Directed frames
// cover the corner blends, borders and size limits. Random frames follow under
// three input/output idling patterns, after one directed long output hold.
// ----------------------------------------------------------------------------
module tb_bilinear_gradient_generator;
    import bgg_pkg::*;

    localparam int     CLK_HALF_NS   = 10;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 300;
    localparam longint TIMEOUT_NS    = 64'd60_000_000;

    // one pixel word as it leaves the block
    typedef struct packed {
        logic [31:0] pixel;
        logic        end_of_row;
        logic        end_of_frame;
    } t_px_word;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_restart   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [31:0]          o_pixel;
    logic                 o_end_of_row;
    logic                 o_end_of_frame;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    // pixel words still owed by the block, oldest first
    t_px_word    expected_pixels[$];
    t_px_word    want;
    int          err_count     = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int          hold_left     = 0;

    // register image kept by the bench
    logic [31:0] reg_tl     = '0;
    logic [31:0] reg_tr     = '0;
    logic [31:0] reg_bl     = '0;
    logic [31:0] reg_br     = '0;
    logic [12:0] reg_width  = 13'd1;
    logic [12:0] reg_height = 13'd1;
    logic [11:0] reg_border = '0;
    logic [31:0] reg_bcolor = '0;

    // gradient state: 8.16 edge values per component, packed 8.8 row pairs
    logic [31:0] lft_acc [4];
    logic [31:0] rgt_acc [4];
    logic [31:0] lft_inc [4];
    logic [31:0] rgt_inc [4];
    logic [31:0] rb_run  = '0;
    logic [31:0] ga_run  = '0;
    logic [31:0] rb_inc  = '0;
    logic [31:0] ga_inc  = '0;
    bit          rb_down = 1'b0;
    bit          ga_down = 1'b0;
    int unsigned px_col  = 0;
    int unsigned px_row  = 0;

    bilinear_gradient_generator #(
        .MAX_SIDE(MAX_SIDE_DEF)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel       (o_pixel),
        .o_end_of_row  (o_end_of_row),
        .o_end_of_frame(o_end_of_frame),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // effective side length: zero acts as one, clipped at the maximum
    function automatic int unsigned side_len(input logic [12:0] v);
        if (v == 13'd0) return 1;
        if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
        return v;
    endfunction

    // signed span divided by (len - 1), truncated toward zero
    function automatic longint span_step(input logic [31:0] lo, input logic [31:0] hi,
                                         input int unsigned len);
        logic [31:0] diff;
        longint      sdiff;
        diff  = hi - lo;
        sdiff = longint'($signed(diff));
        if (len <= 1) return 0;
        return sdiff / longint'(len - 1);
    endfunction

    // one byte of a colour as 8.16 with the rounding half
    function automatic logic [31:0] comp_fix(input logic [31:0] rgba, input int k);
        return (((rgba >> (24 - 8 * k)) & 32'hFF) << 16) | 32'h8000;
    endfunction

    // two 8.16 steps folded into one 8.8 pair
    function automatic logic [31:0] pack_pair(input longint hi, input longint lo);
        logic [31:0] h;
        logic [31:0] l;
        h = hi[31:0];
        l = lo[31:0];
        return ((h << 8) & 32'hffff0000) | ((l >> 8) & 32'h0000ffff);
    endfunction

    // latch corner colours into the edge accumulators
    function automatic void load_edges(input int unsigned ih);
        logic [31:0] tl, tr, bl, br;
        for (int k = 0; k < 4; k++) begin
            tl = comp_fix(reg_tl, k);
            tr = comp_fix(reg_tr, k);
            bl = comp_fix(reg_bl, k);
            br = comp_fix(reg_br, k);
            lft_acc[k] = tl;
            rgt_acc[k] = tr;
            lft_inc[k] = 32'(span_step(tl, bl, ih));
            rgt_inc[k] = 32'(span_step(tr, br, ih));
        end
    endfunction

    // start an inner row from the current edge values
    function automatic void load_row(input int unsigned iw);
        longint dr, dg, db, da;
        dr = span_step(lft_acc[0], rgt_acc[0], iw);
        dg = span_step(lft_acc[1], rgt_acc[1], iw);
        db = span_step(lft_acc[2], rgt_acc[2], iw);
        da = span_step(lft_acc[3], rgt_acc[3], iw);
        rb_run  = ((lft_acc[0] << 8) & 32'hffff0000) | ((lft_acc[2] >> 8) & 32'h0000ffff);
        ga_run  = ((lft_acc[1] << 8) & 32'hffff0000) | ((lft_acc[3] >> 8) & 32'h0000ffff);
        rb_down = 1'b0;
        ga_down = 1'b0;
        // keep the low member of each pair non-negative
        if (db < 0) begin
            dr      = -dr;
            db      = -db;
            rb_down = 1'b1;
        end
        if (da < 0) begin
            dg      = -dg;
            da      = -da;
            ga_down = 1'b1;
        end
        rb_inc = pack_pair(dr, db);
        ga_inc = pack_pair(dg, da);
    endfunction

    // next pixel word for one accepted input word
    function automatic t_px_word predict_pixel(input logic restart);
        int unsigned w, h, b, iw, ih, x, y;
        bit          all_border;
        t_px_word    res;
        w          = side_len(reg_width);
        h          = side_len(reg_height);
        b          = reg_border;
        all_border = (2 * b >= w) || (2 * b >= h);
        iw         = all_border ? 0 : w - 2 * b;
        ih         = all_border ? 0 : h - 2 * b;

        // position, pulled back in range after a geometry change
        if (restart) begin
            px_col = 0;
            px_row = 0;
        end
        if (px_col >= w) begin
            px_col = 0;
            px_row++;
        end
        if (px_row >= h) begin
            px_row = 0;
            px_col = 0;
        end
        x = px_col;
        y = px_row;

        if (x == 0 && y == 0) load_edges(ih);

        if (all_border || x < b || y < b || x >= w - b || y >= h - b) begin
            res.pixel = reg_bcolor;
        end else begin
            if (x == b) load_row(iw);
            res.pixel = (rb_run & 32'hff00ff00) | ((ga_run & 32'hff00ff00) >> 8);
            rb_run = rb_down ? rb_run - rb_inc : rb_run + rb_inc;
            ga_run = ga_down ? ga_run - ga_inc : ga_run + ga_inc;
            // edges move down after the last inner pixel of the row
            if (x == w - b - 1) begin
                for (int k = 0; k < 4; k++) begin
                    lft_acc[k] += lft_inc[k];
                    rgt_acc[k] += rgt_inc[k];
                end
            end
        end
        res.end_of_row   = (x == w - 1);
        res.end_of_frame = (x == w - 1) && (y == h - 1);

        if (x + 1 >= w) begin
            px_col = 0;
            px_row = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            px_col = x + 1;
        end
        return res;
    endfunction

    // mirror of a register write
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_CORNER_TL: reg_tl     = data;
            REG_CORNER_TR: reg_tr     = data;
            REG_CORNER_BL: reg_bl     = data;
            REG_CORNER_BR: reg_br     = data;
            REG_WIDTH:     reg_width  = data[12:0];
            REG_HEIGHT:    reg_height = data[12:0];
            REG_BORDER:    reg_border = data[11:0];
            REG_BORDER_C:  reg_bcolor = data;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return 32'h0000_0000;
        if (sel == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // register write, with valid dropped once it is taken
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one input word after a random gap, predict it once taken
    task automatic send_word(input logic restart);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_pixels.push_back(predict_pixel(restart));
    endtask

    // stop sending and wait for every owed word
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random geometry, mostly small frames
    task automatic rand_config();
        logic [31:0] wd, hd, bd;
        int unsigned sel;
        sel = $urandom_range(99);
        wd  = $urandom;
        hd  = $urandom;
        bd  = $urandom;
        if (sel < 80) begin
            wd[12:0] = 13'($urandom_range(1, 10));
            hd[12:0] = 13'($urandom_range(1, 8));
            bd[11:0] = 12'($urandom_range(0, 3));
        end else if (sel < 87) begin
            // long rows
            wd[12:0] = 13'($urandom_range(11, 4096));
            hd[12:0] = 13'($urandom_range(1, 4));
            bd[11:0] = 12'($urandom_range(0, 2));
        end else if (sel < 92) begin
            // tall images
            wd[12:0] = 13'($urandom_range(1, 6));
            hd[12:0] = 13'($urandom_range(9, 4096));
            bd[11:0] = 12'($urandom_range(0, 2));
        end else if (sel < 96) begin
            // zero and oversize sides
            wd[12:0] = $urandom_range(1) ? 13'd0 : 13'($urandom_range(4097, 8191));
            hd[12:0] = 13'($urandom_range(0, 3));
            bd[11:0] = 12'($urandom_range(0, 1));
        end else if (sel < 98) begin
            // thick border, mostly covering everything
            wd[12:0] = 13'($urandom_range(1, 12));
            hd[12:0] = 13'($urandom_range(1, 12));
            bd[11:0] = 12'($urandom_range(0, 4095));
        end else begin
            // largest sides with border at exactly half
            wd[12:0] = 13'($urandom_range(4096, 8191));
            hd[12:0] = 13'($urandom_range(4096, 8191));
            bd[11:0] = 12'd2048;
        end
        if ($urandom_range(1)) cfg_write(REG_CORNER_TL, pick_color());
        if ($urandom_range(1)) cfg_write(REG_CORNER_TR, pick_color());
        if ($urandom_range(1)) cfg_write(REG_CORNER_BL, pick_color());
        if ($urandom_range(1)) cfg_write(REG_CORNER_BR, pick_color());
        if ($urandom_range(1)) cfg_write(REG_BORDER_C, pick_color());
        cfg_write(REG_WIDTH, wd);
        cfg_write(REG_HEIGHT, hd);
        cfg_write(REG_BORDER, bd);
    endtask

    // reset geometry: a one pixel image
    task automatic test_reset_defaults();
        send_word(1'b0);
        send_word(1'b1);
    endtask

    // full 4x3 frame, opposite signs on top and bottom rows
    task automatic test_corner_gradient();
        settle();
        cfg_write(REG_CORNER_TL, 32'hFF00_FF00);
        cfg_write(REG_CORNER_TR, 32'h00FF_00FF);
        cfg_write(REG_CORNER_BL, 32'h00FF_00FF);
        cfg_write(REG_CORNER_BR, 32'hFF00_FF00);
        cfg_write(REG_WIDTH, 32'd4);
        cfg_write(REG_HEIGHT, 32'd3);
        cfg_write(REG_BORDER, 32'd0);
        send_word(1'b1);
        repeat (11) send_word(1'b0);
    endtask

    // border of half the width, so every pixel is border
    task automatic test_full_border();
        settle();
        cfg_write(REG_BORDER_C, 32'hA5C3_5A3C);
        cfg_write(REG_WIDTH, 32'd4);
        cfg_write(REG_HEIGHT, 32'd3);
        cfg_write(REG_BORDER, 32'hFFFF_F002);
        send_word(1'b1);
        repeat (2) send_word(1'b0);
    endtask

    // one inner pixel, then restart mid-frame
    task automatic test_single_inner();
        settle();
        cfg_write(REG_WIDTH, 32'd3);
        cfg_write(REG_HEIGHT, 32'd3);
        cfg_write(REG_BORDER, 32'd1);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
        send_word(1'b1);
    endtask

    // oversize and zero sides, position pulled back after shrinking
    task automatic test_size_limits();
        settle();
        cfg_write(REG_WIDTH, 32'hFFFF_FFFF);
        cfg_write(REG_HEIGHT, 32'd3);
        cfg_write(REG_BORDER, 32'd0);
        send_word(1'b1);
        repeat (2) send_word(1'b0);
        // column now past the width: next row
        settle();
        cfg_write(REG_WIDTH, 32'hABCD_E002);
        send_word(1'b0);
        // row now past the height: back to top left
        settle();
        cfg_write(REG_HEIGHT, 32'h0000_2000);
        send_word(1'b0);
        settle();
        cfg_write(REG_WIDTH, 32'h0000_0000);
        send_word(1'b0);
        send_word(1'b1);
        settle();
        cfg_write(REG_WIDTH, 32'd4096);
        cfg_write(REG_HEIGHT, 32'd4096);
        cfg_write(REG_BORDER, 32'd2048);
        send_word(1'b1);
        send_word(1'b0);
    endtask

    // long output hold while input keeps coming, so the block backs up
    task automatic test_backpressure();
        settle();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        cfg_write(REG_WIDTH, 32'd7);
        cfg_write(REG_HEIGHT, 32'd5);
        cfg_write(REG_BORDER, 32'd1);
        hold_left = 400;
        send_word(1'b1);
        repeat (39) send_word(1'b0);
        settle();
    endtask

    // random frames in bursts, reconfigured between most bursts
    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                       input int n_words);
        int sent;
        int burst;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        while (sent < n_words) begin
            if ($urandom_range(3) != 0) begin
                settle();
                rand_config();
            end
            burst = $urandom_range(10, 90);
            repeat (burst) begin
                send_word($urandom_range(99) < 4);
                sent++;
            end
        end
    endtask

    // output stall: random, or a long counted hold
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // compare each taken word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected word: pixel %h with nothing pending", o_pixel);
                err_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel !== want.pixel) begin
                    $error("pixel: expected %h, actual %h", want.pixel, o_pixel);
                    err_count++;
                end
                if (o_end_of_row !== want.end_of_row) begin
                    $error("end_of_row: expected %b, actual %b", want.end_of_row, o_end_of_row);
                    err_count++;
                end
                if (o_end_of_frame !== want.end_of_frame) begin
                    $error("end_of_frame: expected %b, actual %b",
                           want.end_of_frame, o_end_of_frame);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // test sequence
    initial begin
        for (int k = 0; k < 4; k++) begin
            lft_acc[k] = '0;
            rgt_acc[k] = '0;
            lft_inc[k] = '0;
            rgt_inc[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 10;
        sink_idle_pct = 30;
        test_reset_defaults();
        test_corner_gradient();
        test_full_border();
        test_single_inner();
        test_size_limits();
        test_backpressure();
        test_random_traffic(22, 88, 500);
        test_random_traffic(88, 22, 500);
        test_random_traffic(0, 0, 500);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
sv/bgg_pkg.sv
sv/bgg_front.sv
sv/bgg_fifo.sv
sv/bgg_div.sv
sv/bgg_back.sv
sv/bilinear_gradient_generator.sv
tb/sv/tb_bilinear_gradient_generator.sv
